FILE: rtl/rfp_pkg.sv
// Shared constants for the reader frame parser: frame bytes, result codes
// and the default EPC store depth. No dependencies.
package rfp_pkg;

  localparam int DefMaxEpcBytes = 16;

  localparam logic [7:0] HdrByte     = 8'hBB;
  localparam logic [7:0] NoTagType   = 8'h01;
  localparam logic [7:0] NoTagCmd    = 8'hFF;
  localparam logic [7:0] EndByte     = 8'h7E;
  localparam logic [15:0] FixedLen   = 16'd5;
  localparam int NoTagTail           = 5;

  localparam logic KindStatus = 1'b0;
  localparam logic KindEpc    = 1'b1;

  localparam logic [1:0] StValid  = 2'd0;
  localparam logic [1:0] StNoTag  = 2'd1;
  localparam logic [1:0] StBadEnd = 2'd2;
  localparam logic [1:0] StLenErr = 2'd3;

endpackage

FILE: rtl/rfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rfid_reader_frame_parser.sv
// A status record is registered in the cycle after the byte that causes it;
// each EPC record waits for a registered read of the EPC store after the previous one.
// Throughput: one byte per cycle while parsing; input stalls on output stall and EPC readout.
// Reset (rst, synchronous): parser hunts for header, output empty, store contents stale.
// Uses rfp_pkg and rfp_ram.
module rfid_reader_frame_parser
  import rfp_pkg::*;
#(
  parameter int MAX_EPC_BYTES = DefMaxEpcBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [7:0]  frame_type,
  output logic [7:0]  command,
  output logic [7:0]  rssi,
  output logic [15:0] protocol_control,
  output logic [15:0] tag_check,
  output logic [4:0]  epc_length,
  output logic        checksum_ok,
  output logic [7:0]  epc_byte,
  output logic        last
);

  localparam int CW0 = $clog2(MAX_EPC_BYTES + 1);
  localparam int CW  = (CW0 < 3) ? 3 : CW0;
  localparam int AW  = (MAX_EPC_BYTES > 1) ? $clog2(MAX_EPC_BYTES) : 1;
  localparam logic [15:0] MaxElen = 16'(MAX_EPC_BYTES);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_TYPE   = 4'd1;
  localparam logic [3:0] PH_CMD    = 4'd2;
  localparam logic [3:0] PH_EMPTY  = 4'd3;
  localparam logic [3:0] PH_LEN_HI = 4'd4;
  localparam logic [3:0] PH_LEN_LO = 4'd5;
  localparam logic [3:0] PH_RSSI   = 4'd6;
  localparam logic [3:0] PH_PC_HI  = 4'd7;
  localparam logic [3:0] PH_PC_LO  = 4'd8;
  localparam logic [3:0] PH_EPC    = 4'd9;
  localparam logic [3:0] PH_TC_HI  = 4'd10;
  localparam logic [3:0] PH_TC_LO  = 4'd11;
  localparam logic [3:0] PH_SUM    = 4'd12;
  localparam logic [3:0] PH_END    = 4'd13;

  logic [3:0]    phase;
  logic [CW-1:0] cnt;
  logic [7:0]    sum_acc;
  logic [15:0]   length_word;
  logic [CW-1:0] elen;
  logic [7:0]    type_byte;
  logic [7:0]    cmd_byte;
  logic [7:0]    rssi_byte;
  logic [15:0]   pc_word;
  logic [15:0]   tc_word;
  logic [7:0]    sum_rx;

  logic          emitting;
  logic          data_ready;
  logic [CW-1:0] rd_idx;
  logic [7:0]    rd_data;

  logic          acc;
  logic          rec_load;
  logic [1:0]    rec_status;
  logic          rec_full;
  logic          rec_last;
  logic          epc_load;
  logic          ram_we;
  logic [15:0]   len_full;
  logic [CW-1:0] cnt_inc;
  logic          sum_match;

  assign rx_stall  = emitting || (res_valid && res_stall);
  assign acc       = rx_valid && !rx_stall;
  assign len_full  = {length_word[15:8], rx_byte};
  assign cnt_inc   = cnt + CW'(1);
  assign sum_match = (sum_acc == sum_rx);
  assign ram_we    = acc && (phase == PH_EPC);
  assign epc_load  = emitting && data_ready && (!res_valid || !res_stall);

  always_comb begin
    rec_load   = 1'b0;
    rec_status = StValid;
    rec_full   = 1'b0;
    rec_last   = 1'b1;
    if (acc) begin
      case (phase)
        PH_EMPTY: begin
          if (cnt_inc >= CW'(NoTagTail)) begin
            rec_load   = 1'b1;
            rec_status = StNoTag;
          end
        end
        PH_LEN_LO: begin
          if (len_full < FixedLen || (len_full - FixedLen) > MaxElen) begin
            rec_load   = 1'b1;
            rec_status = StLenErr;
          end
        end
        PH_END: begin
          rec_load = 1'b1;
          rec_full = 1'b1;
          if (rx_byte != EndByte) begin
            rec_status = StBadEnd;
          end else begin
            rec_last = (elen == '0);
          end
        end
        default: begin
          rec_load = 1'b0;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      cnt         <= '0;
      sum_acc     <= '0;
      length_word <= '0;
      elen        <= '0;
      type_byte   <= '0;
      cmd_byte    <= '0;
      rssi_byte   <= '0;
      pc_word     <= '0;
      tc_word     <= '0;
      sum_rx      <= '0;
    end else if (acc) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == HdrByte) begin
            phase <= PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_byte <= rx_byte;
          sum_acc   <= rx_byte;
          phase     <= PH_CMD;
        end
        PH_CMD: begin
          cmd_byte <= rx_byte;
          sum_acc  <= sum_acc + rx_byte;
          if (type_byte == NoTagType && rx_byte == NoTagCmd) begin
            cnt   <= '0;
            phase <= PH_EMPTY;
          end else begin
            phase <= PH_LEN_HI;
          end
        end
        PH_EMPTY: begin
          if (cnt_inc >= CW'(NoTagTail)) begin
            cnt   <= '0;
            phase <= PH_HUNT;
          end else begin
            cnt <= cnt_inc;
          end
        end
        PH_LEN_HI: begin
          length_word <= {rx_byte, 8'h00};
          sum_acc     <= sum_acc + rx_byte;
          phase       <= PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_word <= len_full;
          elen        <= CW'(len_full - FixedLen);
          sum_acc     <= sum_acc + rx_byte;
          if (len_full < FixedLen || (len_full - FixedLen) > MaxElen) begin
            phase <= PH_HUNT;
          end else begin
            phase <= PH_RSSI;
          end
        end
        PH_RSSI: begin
          rssi_byte <= rx_byte;
          sum_acc   <= sum_acc + rx_byte;
          phase     <= PH_PC_HI;
        end
        PH_PC_HI: begin
          pc_word <= {rx_byte, 8'h00};
          sum_acc <= sum_acc + rx_byte;
          phase   <= PH_PC_LO;
        end
        PH_PC_LO: begin
          pc_word <= {pc_word[15:8], rx_byte};
          sum_acc <= sum_acc + rx_byte;
          cnt     <= '0;
          phase   <= (elen == '0) ? PH_TC_HI : PH_EPC;
        end
        PH_EPC: begin
          sum_acc <= sum_acc + rx_byte;
          cnt     <= cnt_inc;
          if (cnt_inc >= elen) begin
            phase <= PH_TC_HI;
          end
        end
        PH_TC_HI: begin
          tc_word <= {rx_byte, 8'h00};
          sum_acc <= sum_acc + rx_byte;
          phase   <= PH_TC_LO;
        end
        PH_TC_LO: begin
          tc_word <= {tc_word[15:8], rx_byte};
          sum_acc <= sum_acc + rx_byte;
          phase   <= PH_SUM;
        end
        PH_SUM: begin
          sum_rx <= rx_byte;
          phase  <= PH_END;
        end
        PH_END: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

  rfp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_EPC_BYTES)
  ) u_epc_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(rx_byte),
    .raddr(rd_idx[AW-1:0]),
    .rdata(rd_data)
  );

  // EPC readout sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting   <= 1'b0;
      data_ready <= 1'b0;
      rd_idx     <= '0;
    end else if (rec_load && !rec_last) begin
      emitting   <= 1'b1;
      data_ready <= 1'b0;
      rd_idx     <= '0;
    end else if (epc_load) begin
      data_ready <= 1'b0;
      rd_idx     <= rd_idx + CW'(1);
      if (rd_idx == elen - CW'(1)) begin
        emitting <= 1'b0;
      end
    end else begin
      data_ready <= emitting;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rec_load || epc_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      kind             <= KindStatus;
      status           <= rec_status;
      frame_type       <= type_byte;
      command          <= (phase == PH_CMD) ? rx_byte : cmd_byte;
      rssi             <= rec_full ? rssi_byte : 8'h00;
      protocol_control <= rec_full ? pc_word : 16'h0000;
      tag_check        <= rec_full ? tc_word : 16'h0000;
      epc_length       <= rec_full ? 5'(elen) : 5'd0;
      checksum_ok      <= rec_full ? sum_match : 1'b0;
      epc_byte         <= 8'h00;
      last             <= rec_last;
    end else if (epc_load) begin
      kind     <= KindEpc;
      status   <= StValid;
      epc_byte <= rd_data;
      last     <= (rd_idx == elen - CW'(1));
    end
  end

`ifndef SYNTHESIS
  a_epc_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KindEpc) |-> (status == StValid))
    else $error("EPC record without valid status");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !last) |-> emitting)
    else $error("non-final record with no readout pending");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    emitting |-> (rd_idx < elen))
    else $error("EPC readout index beyond frame length");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (cnt < elen && {{(16-CW){1'b0}}, cnt} < MaxElen))
    else $error("EPC store write beyond frame length");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (rst)
    emitting |-> !ram_we)
    else $error("EPC store written during readout");
`endif

endmodule

FILE: tb/sv/rfid_reader_frame_parser_test.sv
// Self-checking bench for rfid_reader_frame_parser: feeds tag, no-tag, malformed
// and noise byte streams under several idle/stall mixes and checks every record.
// Depends on rfp_pkg and the parser RTL.
module rfid_reader_frame_parser_test;
  import rfp_pkg::*;

  localparam int EpcDepth    = DefMaxEpcBytes;
  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 60;
  localparam int PhaseBytes  = 60;
  localparam int PrintCap    = 200;
  localparam logic [7:0] TagType = 8'h02;
  localparam logic [7:0] InvCmd  = 8'h22;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  command;
    logic [7:0]  rssi;
    logic [15:0] protocol_control;
    logic [15:0] tag_check;
    logic [4:0]  epc_length;
    logic        checksum_ok;
    logic [7:0]  epc_byte;
    logic        last;
  } frame_rec_t;

  class frame_scoreboard;
    typedef enum logic [3:0] {
      WaitHeader, GetType, GetCmd, SkipEmpty, GetLenHi, GetLenLo, GetRssi,
      GetPcHi, GetPcLo, GetEpc, GetTcHi, GetTcLo, GetSum, GetEnd
    } phase_e;

    phase_e      phase;
    logic [4:0]  count;
    logic [7:0]  sum_acc;
    logic [7:0]  sum_rx;
    logic [7:0]  type_b;
    logic [7:0]  cmd_b;
    logic [7:0]  rssi_b;
    logic [15:0] len_w;
    logic [15:0] pc_w;
    logic [15:0] tc_w;
    logic [7:0]  epc_mem [EpcDepth];
    frame_rec_t  expected_q[$];
    int          errors;
    int          printed;
    int          checked;

    function new();
      phase   = WaitHeader;
      count   = '0;
      sum_acc = '0;
      sum_rx  = '0;
      type_b  = '0;
      cmd_b   = '0;
      rssi_b  = '0;
      len_w   = '0;
      pc_w    = '0;
      tc_w    = '0;
      errors  = 0;
      printed = 0;
      checked = 0;
      foreach (epc_mem[i]) epc_mem[i] = 8'h00;
    endfunction

    function void push_rec(input logic k, input logic [1:0] st, input logic [7:0] r,
                           input logic [15:0] pc, input logic [15:0] tc,
                           input logic [4:0] n, input logic ok, input logic [7:0] eb,
                           input logic lst);
      frame_rec_t rec;
      rec.kind             = k;
      rec.status           = st;
      rec.frame_type       = type_b;
      rec.command          = cmd_b;
      rec.rssi             = r;
      rec.protocol_control = pc;
      rec.tag_check        = tc;
      rec.epc_length       = n;
      rec.checksum_ok      = ok;
      rec.epc_byte         = eb;
      rec.last             = lst;
      expected_q.push_back(rec);
    endfunction

    function void note_byte(input logic [7:0] b);
      int   n;
      logic ok;
      case (phase)
        WaitHeader: if (b == HdrByte) phase = GetType;
        GetType: begin
          type_b  = b;
          sum_acc = b;
          phase   = GetCmd;
        end
        GetCmd: begin
          cmd_b   = b;
          sum_acc = sum_acc + b;
          if (type_b == NoTagType && b == NoTagCmd) begin
            count = '0;
            phase = SkipEmpty;
          end else begin
            phase = GetLenHi;
          end
        end
        SkipEmpty: begin
          count = count + 1'b1;
          if (int'(count) >= NoTagTail) begin
            count = '0;
            phase = WaitHeader;
            push_rec(KindStatus, StNoTag, '0, '0, '0, '0, 1'b0, '0, 1'b1);
          end
        end
        GetLenHi: begin
          len_w   = {b, 8'h00};
          sum_acc = sum_acc + b;
          phase   = GetLenLo;
        end
        GetLenLo: begin
          len_w[7:0] = b;
          sum_acc    = sum_acc + b;
          if (len_w < FixedLen || int'(len_w) - int'(FixedLen) > EpcDepth) begin
            phase = WaitHeader;
            push_rec(KindStatus, StLenErr, '0, '0, '0, '0, 1'b0, '0, 1'b1);
          end else begin
            phase = GetRssi;
          end
        end
        GetRssi: begin
          rssi_b  = b;
          sum_acc = sum_acc + b;
          phase   = GetPcHi;
        end
        GetPcHi: begin
          pc_w    = {b, 8'h00};
          sum_acc = sum_acc + b;
          phase   = GetPcLo;
        end
        GetPcLo: begin
          pc_w[7:0] = b;
          sum_acc   = sum_acc + b;
          count     = '0;
          phase     = (len_w == FixedLen) ? GetTcHi : GetEpc;
        end
        GetEpc: begin
          if (int'(count) < EpcDepth) epc_mem[count] = b;
          sum_acc = sum_acc + b;
          count   = count + 1'b1;
          if (int'(count) >= int'(len_w) - int'(FixedLen)) phase = GetTcHi;
        end
        GetTcHi: begin
          tc_w    = {b, 8'h00};
          sum_acc = sum_acc + b;
          phase   = GetTcLo;
        end
        GetTcLo: begin
          tc_w[7:0] = b;
          sum_acc   = sum_acc + b;
          phase     = GetSum;
        end
        GetSum: begin
          sum_rx = b;
          phase  = GetEnd;
        end
        GetEnd: begin
          ok    = (sum_acc == sum_rx);
          phase = WaitHeader;
          n     = int'(len_w) - int'(FixedLen);
          if (n > EpcDepth) n = EpcDepth;
          if (b != EndByte) begin
            push_rec(KindStatus, StBadEnd, rssi_b, pc_w, tc_w, 5'(n), ok, '0, 1'b1);
          end else begin
            push_rec(KindStatus, StValid, rssi_b, pc_w, tc_w, 5'(n), ok, '0, n == 0);
            for (int k = 0; k < n; k++)
              push_rec(KindEpc, StValid, rssi_b, pc_w, tc_w, 5'(n), ok, epc_mem[k],
                       k + 1 == n);
          end
        end
        default: phase = WaitHeader;
      endcase
    endfunction

    task report(input string msg);
      errors++;
      if (printed < PrintCap) $display("ERROR: %s", msg);
      printed++;
    endtask

    function void field_diff(inout string s, input string name, input logic [15:0] g,
                             input logic [15:0] w);
      if (g !== w) s = {s, $sformatf(" %s %0h/%0h", name, g, w)};
    endfunction

    task check_result(input frame_rec_t got);
      frame_rec_t want;
      string      diffs;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected record kind %0h status %0h epc_byte %0h",
                         got.kind, got.status, got.epc_byte));
        return;
      end
      want  = expected_q.pop_front();
      diffs = "";
      field_diff(diffs, "kind", got.kind, want.kind);
      field_diff(diffs, "status", got.status, want.status);
      field_diff(diffs, "frame_type", got.frame_type, want.frame_type);
      field_diff(diffs, "command", got.command, want.command);
      field_diff(diffs, "rssi", got.rssi, want.rssi);
      field_diff(diffs, "protocol_control", got.protocol_control, want.protocol_control);
      field_diff(diffs, "tag_check", got.tag_check, want.tag_check);
      field_diff(diffs, "epc_length", got.epc_length, want.epc_length);
      field_diff(diffs, "checksum_ok", got.checksum_ok, want.checksum_ok);
      field_diff(diffs, "epc_byte", got.epc_byte, want.epc_byte);
      field_diff(diffs, "last", got.last, want.last);
      if (diffs != "") report($sformatf("record %0d got/expected:%s", checked, diffs));
      checked++;
    endtask

    task finish_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected records never arrived", expected_q.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        kind;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  command;
  logic [7:0]  rssi;
  logic [15:0] protocol_control;
  logic [15:0] tag_check;
  logic [4:0]  epc_length;
  logic        checksum_ok;
  logic [7:0]  epc_byte;
  logic        last;

  frame_scoreboard board;
  logic [7:0]      frame_q[$];
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              sent = 0;
  int              quiet = 0;
  logic            holding = 1'b0;
  event            hold_ev;

  rfid_reader_frame_parser i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold the result side off for a long stretch on request.
  initial forever begin
    @(hold_ev);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall)
        board.check_result('{kind, status, frame_type, command, rssi, protocol_control,
                             tag_check, epc_length, checksum_ok, epc_byte, last});
      res_stall <= holding || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet >= IdleLimit) begin
      $display("rfid_reader_frame_parser_test NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      rx_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    board.note_byte(b);
    sent++;
  endtask

  task automatic send_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic wait_drained();
    rx_valid <= 1'b0;
    do @(posedge clk); while (board.expected_q.size() != 0);
  endtask

  function automatic void add_tag_frame(input logic [7:0] typ, input logic [7:0] cmd,
                                        input int epc_n, input bit bad_sum,
                                        input logic [7:0] end_b, input logic [7:0] rssi_v,
                                        input logic [15:0] pc_v, input logic [15:0] tc_v);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [15:0] len;
    len  = 16'(epc_n + 5);
    body = '{typ, cmd, len[15:8], len[7:0], rssi_v, pc_v[15:8], pc_v[7:0]};
    repeat (epc_n) body.push_back(8'($urandom));
    body.push_back(tc_v[15:8]);
    body.push_back(tc_v[7:0]);
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    frame_q.push_back(HdrByte);
    foreach (body[i]) frame_q.push_back(body[i]);
    frame_q.push_back(sum);
    frame_q.push_back(end_b);
  endfunction

  function automatic void add_len_error(input logic [7:0] typ, input logic [7:0] cmd,
                                        input logic [15:0] len);
    frame_q.push_back(HdrByte);
    frame_q.push_back(typ);
    frame_q.push_back(cmd);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
  endfunction

  function automatic void add_no_tag();
    frame_q.push_back(HdrByte);
    frame_q.push_back(NoTagType);
    frame_q.push_back(NoTagCmd);
    repeat (NoTagTail) frame_q.push_back(8'($urandom));
  endfunction

  task automatic send_random_frame();
    int          pick;
    int          epc_n;
    logic [7:0]  typ;
    logic [15:0] bad_len;
    pick  = $urandom_range(99);
    typ   = ($urandom_range(4) == 0) ? 8'($urandom) : TagType;
    epc_n = ($urandom_range(9) < 7) ? $urandom_range(4) : $urandom_range(EpcDepth);
    if (pick < 55 || pick >= 85) begin
      add_tag_frame(typ, ($urandom_range(4) == 0) ? 8'($urandom) : InvCmd, epc_n,
                    $urandom_range(99) < 15,
                    ($urandom_range(9) == 0) ? 8'($urandom) : EndByte,
                    8'($urandom), 16'($urandom), 16'($urandom));
      // drop the tail to leave a broken frame
      if (pick >= 85) repeat ($urandom_range(frame_q.size() - 2, 1)) void'(frame_q.pop_back());
    end else if (pick < 65) begin
      add_no_tag();
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0:       bad_len = 16'($urandom_range(4));
        1:       bad_len = 16'(EpcDepth + 6);
        2:       bad_len = 16'($urandom_range(65535, EpcDepth + 6));
        default: bad_len = 16'hFFFF;
      endcase
      add_len_error(typ, InvCmd, bad_len);
    end else begin
      repeat ($urandom_range(4, 1)) frame_q.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin
    int start;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_no_tag();
    add_len_error(TagType, InvCmd, 16'd4);
    add_tag_frame(TagType, InvCmd, 0, 1'b1, 8'h00, 8'hFF, 16'hFFFF, 16'hBB00);
    send_frame();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (ph == 0) begin
        -> hold_ev;
        repeat (3) begin
          add_tag_frame(TagType, InvCmd, EpcDepth, 1'b0, EndByte, 8'($urandom),
                        16'($urandom), 16'($urandom));
          send_frame();
        end
        wait_drained();
      end
      start = sent;
      while (sent - start < PhaseBytes) send_random_frame();
    end

    rx_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    board.finish_check();
    if (board.errors == 0) $display("rfid_reader_frame_parser_test OK");
    else $display("rfid_reader_frame_parser_test NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rfp_pkg.sv
rtl/rfp_ram.sv
rtl/rfid_reader_frame_parser.sv
tb/sv/rfid_reader_frame_parser_test.sv
